### rtl/float_add_subtract_macros.svh
// assertion helpers for the adder block
`ifndef FLOAT_ADD_SUBTRACT_MACROS_SVH
`define FLOAT_ADD_SUBTRACT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FPAS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FPAS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fpas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpas_pkg;

   localparam int FRAC_W  = 23;
   localparam int GUARD_W = 40;
   localparam int SIG_W   = FRAC_W + 1;
   localparam int WIN_W   = SIG_W + GUARD_W;
   localparam int ACC_W   = WIN_W + 1;
   localparam int CNT_W   = $clog2(WIN_W + 1);
   localparam int EXP_W   = 8;
   localparam int BE_W    = EXP_W + 2;
   localparam int KEEP_W  = 5;
   localparam int EBITS_W = 4;
   localparam int CSR_W   = 5;

   localparam int EXP_BIAS = 127;
   localparam int EXP_MAX  = 127;
   localparam int EXP_MIN  = -126;

   // limits on the biased exponent
   localparam logic signed [BE_W-1:0] BE_HI_LIM = BE_W'(EXP_BIAS + EXP_MAX);
   localparam logic signed [BE_W-1:0] BE_LO_LIM = BE_W'(EXP_BIAS + EXP_MIN);

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_ZERO = 2'd1,
      STAT_OVF  = 2'd2,
      STAT_UNF  = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_NORM
   } state_type;

   typedef enum logic [2:0] {
      UOP_HOLD,
      UOP_LOAD,
      UOP_SHR,
      UOP_COMBINE,
      UOP_SHL
   } uop_type;

   typedef enum logic {
      CSR_FRAC_BITS = 1'b0,
      CSR_EXP_BITS  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic cnt_zero;
      logic lead_one;
      logic acc_zero;
   } unit_flags_type;

endpackage

`default_nettype wire

### rtl/fpas_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module fpas_unit (
   input  wire logic                             clock,
   input  wire fpas_pkg::uop_type                op,
   input  wire logic                             ld_sub,
   input  wire logic [fpas_pkg::FRAC_W-1:0]      ld_frac_a,
   input  wire logic [fpas_pkg::EXP_W-1:0]       ld_exp_a,
   input  wire logic [fpas_pkg::FRAC_W-1:0]      ld_frac_b,
   input  wire logic [fpas_pkg::EXP_W-1:0]       ld_exp_b,
   output fpas_pkg::unit_flags_type              flags,
   output logic [fpas_pkg::FRAC_W-1:0]           acc_frac,
   output logic [fpas_pkg::CNT_W-1:0]            norm_cnt,
   output logic [fpas_pkg::EXP_W-1:0]            emax,
   output logic                                  sign
);

   // acc holds the operand being aligned, then the sum being normalized
   logic [fpas_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [fpas_pkg::WIN_W-1:0] big_ff, big_in;
   logic [fpas_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [fpas_pkg::EXP_W-1:0] emax_ff, emax_in;
   logic                       swap_ff, swap_in;
   logic                       sub_ff, sub_in;
   logic                       sign_ff, sign_in;

   logic [fpas_pkg::WIN_W-1:0] a_win, b_win, a_v, b_v, dif;
   logic [fpas_pkg::ACC_W-1:0] sum;
   logic [fpas_pkg::EXP_W-1:0] ediff;
   logic                       a_ge_b_exp, ge;

   always_comb begin
      a_win      = {1'b1, ld_frac_a, fpas_pkg::GUARD_W'(0)};
      b_win      = {1'b1, ld_frac_b, fpas_pkg::GUARD_W'(0)};
      a_ge_b_exp = ld_exp_a >= ld_exp_b;
      ediff      = a_ge_b_exp ? ld_exp_a - ld_exp_b : ld_exp_b - ld_exp_a;

      a_v = swap_ff ? acc_ff[fpas_pkg::WIN_W-1:0] : big_ff;
      b_v = swap_ff ? big_ff : acc_ff[fpas_pkg::WIN_W-1:0];
      sum = {1'b0, a_v} + {1'b0, b_v};
      ge  = a_v >= b_v;
      dif = ge ? a_v - b_v : b_v - a_v;

      acc_in  = acc_ff;
      big_in  = big_ff;
      cnt_in  = cnt_ff;
      emax_in = emax_ff;
      swap_in = swap_ff;
      sub_in  = sub_ff;
      sign_in = sign_ff;

      unique case (op)
         fpas_pkg::UOP_LOAD: begin
            sub_in  = ld_sub;
            sign_in = 1'b0;
            swap_in = !a_ge_b_exp;
            emax_in = a_ge_b_exp ? ld_exp_a : ld_exp_b;
            big_in  = a_ge_b_exp ? a_win : b_win;
            acc_in  = {1'b0, (a_ge_b_exp ? b_win : a_win)};
            // anything shifted past the window is simply zero
            if (int'(ediff) >= fpas_pkg::WIN_W) begin
               cnt_in = fpas_pkg::CNT_W'(fpas_pkg::WIN_W);
            end else begin
               cnt_in = fpas_pkg::CNT_W'(ediff);
            end
         end
         fpas_pkg::UOP_SHR: begin
            acc_in = acc_ff >> 1;
            cnt_in = cnt_ff - fpas_pkg::CNT_W'(1);
         end
         fpas_pkg::UOP_COMBINE: begin
            acc_in  = sub_ff ? {1'b0, dif} : sum;
            sign_in = sub_ff & !ge;
            cnt_in  = '0;
         end
         fpas_pkg::UOP_SHL: begin
            acc_in = acc_ff << 1;
            cnt_in = cnt_ff + fpas_pkg::CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      big_ff  <= big_in;
      cnt_ff  <= cnt_in;
      emax_ff <= emax_in;
      swap_ff <= swap_in;
      sub_ff  <= sub_in;
      sign_ff <= sign_in;
   end

   assign flags.cnt_zero = cnt_ff == '0;
   assign flags.lead_one = acc_ff[fpas_pkg::ACC_W-1];
   assign flags.acc_zero = acc_ff == '0;
   assign acc_frac       = acc_ff[fpas_pkg::ACC_W-2 -: fpas_pkg::FRAC_W];
   assign norm_cnt       = cnt_ff;
   assign emax           = emax_ff;
   assign sign           = sign_ff;

endmodule

`default_nettype wire

### rtl/float_add_subtract.sv
// after the load, ST_ALIGN shifts d times then combines; ST_NORM shifts n times, then
//   finish is registered into rsp_valid; d = min(|exp_a - exp_b|, 64), n = 0..64
// a shared one-bit shifter and add/subtract logic do the work; busy is high meanwhile
// a new item waits until the last is done: start is taken again in the strobe cycle
// reset clears the sequencer and strobe, and sets the field widths to 23 and 8
// rsp_valid is not held: it is high for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

`include "float_add_subtract_macros.svh"

module float_add_subtract (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_type,
   input  wire logic [fpas_pkg::FRAC_W-1:0]     req_frac_a,
   input  wire logic [fpas_pkg::EXP_W-1:0]      req_exp_a,
   input  wire logic [fpas_pkg::FRAC_W-1:0]     req_frac_b,
   input  wire logic [fpas_pkg::EXP_W-1:0]      req_exp_b,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_sign_out,
   output logic [fpas_pkg::EXP_W-1:0]           rsp_exp_out,
   output logic [fpas_pkg::FRAC_W-1:0]          rsp_frac_out,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic                            csr_index,
   input  wire logic [fpas_pkg::CSR_W-1:0]      csr_wdata
);

   fpas_pkg::state_type              state_ff, state_in;
   fpas_pkg::uop_type                op;
   fpas_pkg::unit_flags_type         flags;
   logic                             finish;

   logic [fpas_pkg::KEEP_W-1:0]      keep_ff, keep_in;
   logic [fpas_pkg::EBITS_W-1:0]     ebits_ff, ebits_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   fpas_pkg::stat_type               rsp_status_ff, rsp_status_in;
   logic                             rsp_sign_ff, rsp_sign_in;
   logic [fpas_pkg::EXP_W-1:0]       rsp_exp_ff, rsp_exp_in;
   logic [fpas_pkg::FRAC_W-1:0]      rsp_frac_ff, rsp_frac_in;

   logic [fpas_pkg::FRAC_W-1:0]      acc_frac, fmask;
   logic [fpas_pkg::CNT_W-1:0]       norm_cnt;
   logic [fpas_pkg::EXP_W-1:0]       emax, emask;
   logic                             sign;
   logic signed [fpas_pkg::BE_W-1:0] be;

   fpas_unit u_unit (
      .clock     (clock),
      .op        (op),
      .ld_sub    (req_type),
      .ld_frac_a (req_frac_a),
      .ld_exp_a  (req_exp_a),
      .ld_frac_b (req_frac_b),
      .ld_exp_b  (req_exp_b),
      .flags     (flags),
      .acc_frac  (acc_frac),
      .norm_cnt  (norm_cnt),
      .emax      (emax),
      .sign      (sign)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      op       = fpas_pkg::UOP_HOLD;
      finish   = 1'b0;
      unique case (state_ff)
         fpas_pkg::ST_IDLE: begin
            if (start) begin
               op       = fpas_pkg::UOP_LOAD;
               state_in = fpas_pkg::ST_ALIGN;
            end
         end
         fpas_pkg::ST_ALIGN: begin
            if (flags.cnt_zero) begin
               op       = fpas_pkg::UOP_COMBINE;
               state_in = fpas_pkg::ST_NORM;
            end else begin
               op = fpas_pkg::UOP_SHR;
            end
         end
         fpas_pkg::ST_NORM: begin
            if (flags.acc_zero || flags.lead_one) begin
               finish   = 1'b1;
               state_in = fpas_pkg::ST_IDLE;
            end else begin
               op = fpas_pkg::UOP_SHL;
            end
         end
         default: begin
            state_in = fpas_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_comb begin
      keep_in  = keep_ff;
      ebits_in = ebits_ff;
      if (csr_valid && csr_ready) begin
         unique case (fpas_pkg::csr_idx_type'(csr_index))
            fpas_pkg::CSR_FRAC_BITS: keep_in  = csr_wdata;
            fpas_pkg::CSR_EXP_BITS:  ebits_in = csr_wdata[fpas_pkg::EBITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff  <= fpas_pkg::KEEP_W'(fpas_pkg::FRAC_W);
         ebits_ff <= fpas_pkg::EBITS_W'(fpas_pkg::EXP_W);
      end else begin
         keep_ff  <= keep_in;
         ebits_ff <= ebits_in;
      end
   end

   // result formatting; the leading one sits at the top of acc
   always_comb begin
      fmask = ~({fpas_pkg::FRAC_W{1'b1}} >> keep_ff);
      emask = ~({fpas_pkg::EXP_W{1'b1}} << ebits_ff);
      be    = fpas_pkg::BE_W'(emax) + fpas_pkg::BE_W'(1) - fpas_pkg::BE_W'(norm_cnt);

      rsp_valid_in  = finish;
      rsp_status_in = fpas_pkg::STAT_OK;
      rsp_sign_in   = sign;
      rsp_exp_in    = '0;
      rsp_frac_in   = '0;
      priority if (flags.acc_zero) begin
         rsp_status_in = fpas_pkg::STAT_ZERO;
         rsp_sign_in   = 1'b0;
      end else if (be > fpas_pkg::BE_HI_LIM) begin
         rsp_status_in = fpas_pkg::STAT_OVF;
      end else if (be < fpas_pkg::BE_LO_LIM) begin
         rsp_status_in = fpas_pkg::STAT_UNF;
      end else begin
         rsp_exp_in  = be[fpas_pkg::EXP_W-1:0] & emask;
         rsp_frac_in = acc_frac & fmask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_sign_ff   <= rsp_sign_in;
         rsp_exp_ff    <= rsp_exp_in;
         rsp_frac_ff   <= rsp_frac_in;
      end
   end

   assign busy         = state_ff != fpas_pkg::ST_IDLE;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_sign_out = rsp_sign_ff;
   assign rsp_exp_out  = rsp_exp_ff;
   assign rsp_frac_out = rsp_frac_ff;

   `FPAS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `FPAS_ASSERT_IMP(a_rsp_idle, rsp_valid_ff, !busy, "result beat while still busy")
   `FPAS_ASSERT_IMP(a_align_top, state_ff == fpas_pkg::ST_ALIGN, !flags.lead_one, "align overflowed")

endmodule

`default_nettype wire

### tb/sv/tb_float_add_subtract.sv
`timescale 1ns / 1ps

module tb_float_add_subtract;
   import fpas_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int ITEMS_PER_PHASE = 156;
   localparam int TAIL_CYCLES     = 140;
   localparam int MAX_GAP         = 60;

   typedef struct {
      logic              sub;
      logic [FRAC_W-1:0] frac_a;
      logic [EXP_W-1:0]  exp_a;
      logic [FRAC_W-1:0] frac_b;
      logic [EXP_W-1:0]  exp_b;
   } fp_operation_t;

   typedef struct {
      stat_type          status;
      logic              sign;
      logic [EXP_W-1:0]  exponent;
      logic [FRAC_W-1:0] fraction;
   } fp_sum_t;

   class fp_sum_board;
      logic [KEEP_W-1:0]  frac_keep;
      logic [EBITS_W-1:0] exp_keep;
      fp_sum_t            sum_queue[$];
      int                 errors;

      function new();
         frac_keep = 5'd23;
         exp_keep  = 4'd8;
         errors    = 0;
      endfunction

      function void set_register(csr_idx_type idx, logic [CSR_W-1:0] data);
         if (idx == CSR_FRAC_BITS) frac_keep = data[KEEP_W-1:0];
         else exp_keep = data[EBITS_W-1:0];
      endfunction

      function fp_sum_t predict_sum(fp_operation_t op);
         logic [127:0]      mag_a, mag_b, total, norm;
         logic [31:0]       frac_mask, exp_mask;
         int                emax, top, e, keep, ebits;
         fp_sum_t           res;
         res.status   = STAT_OK;
         res.sign     = 1'b0;
         res.exponent = '0;
         res.fraction = '0;
         mag_a = 128'({1'b1, op.frac_a}) << GUARD_W;
         mag_b = 128'({1'b1, op.frac_b}) << GUARD_W;
         if (op.exp_a >= op.exp_b) begin
            mag_b = mag_b >> (op.exp_a - op.exp_b);
            emax  = op.exp_a;
         end else begin
            mag_a = mag_a >> (op.exp_b - op.exp_a);
            emax  = op.exp_b;
         end
         if (!op.sub) total = mag_a + mag_b;
         else if (mag_a >= mag_b) total = mag_a - mag_b;
         else begin
            total    = mag_b - mag_a;
            res.sign = 1'b1;
         end
         top = -1;
         for (int i = 0; i < 128; i++) if (total[i]) top = i;
         if (top < 0) begin
            res.status = STAT_ZERO;
            res.sign   = 1'b0;
            return res;
         end
         e = emax - EXP_BIAS + top - (FRAC_W + GUARD_W);
         if (e > EXP_MAX) begin
            res.status = STAT_OVF;
            return res;
         end
         if (e < EXP_MIN) begin
            res.status = STAT_UNF;
            return res;
         end
         if (top >= FRAC_W) norm = total >> (top - FRAC_W);
         else norm = total << (FRAC_W - top);
         keep = (frac_keep > FRAC_W) ? FRAC_W : int'(frac_keep);
         frac_mask = ~((32'd1 << (FRAC_W - keep)) - 32'd1);
         res.fraction = norm[FRAC_W-1:0] & frac_mask[FRAC_W-1:0];
         ebits = (exp_keep > 8) ? 8 : int'(exp_keep);
         exp_mask = (32'd1 << ebits) - 32'd1;
         res.exponent = 8'(32'(e + EXP_BIAS) & exp_mask);
         return res;
      endfunction

      function void note_operation(fp_operation_t op);
         sum_queue.push_back(predict_sum(op));
      endfunction

      function void check_result(fp_sum_t got);
         fp_sum_t want;
         if (sum_queue.size() == 0) begin
            $error("rsp beat with no pending operation");
            errors++;
            return;
         end
         want = sum_queue.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.sign !== want.sign) begin
            $error("sign_out: expected %0d, got %0d", want.sign, got.sign);
            errors++;
         end
         if (got.exponent !== want.exponent) begin
            $error("exp_out: expected 0x%0h, got 0x%0h", want.exponent, got.exponent);
            errors++;
         end
         if (got.fraction !== want.fraction) begin
            $error("frac_out: expected 0x%0h, got 0x%0h", want.fraction, got.fraction);
            errors++;
         end
      endfunction

      function int pending();
         return sum_queue.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_type = 1'b0;
   logic [FRAC_W-1:0] req_frac_a = '0;
   logic [EXP_W-1:0]  req_exp_a = '0;
   logic [FRAC_W-1:0] req_frac_b = '0;
   logic [EXP_W-1:0]  req_exp_b = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic              rsp_sign_out;
   logic [EXP_W-1:0]  rsp_exp_out;
   logic [FRAC_W-1:0] rsp_frac_out;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   fp_sum_board board;
   int          idle_cycles = 0;

   float_add_subtract uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_frac_a   (req_frac_a),
      .req_exp_a    (req_exp_a),
      .req_frac_b   (req_frac_b),
      .req_exp_b    (req_exp_b),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_sign_out (rsp_sign_out),
      .rsp_exp_out  (rsp_exp_out),
      .rsp_frac_out (rsp_frac_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      fp_operation_t op;
      fp_sum_t       got;
      if (!reset && board != null) begin
         if (rsp_valid) begin
            got.status   = stat_type'(rsp_status);
            got.sign     = rsp_sign_out;
            got.exponent = rsp_exp_out;
            got.fraction = rsp_frac_out;
            board.check_result(got);
         end
         if (start && !busy) begin
            op.sub    = req_type;
            op.frac_a = req_frac_a;
            op.exp_a  = req_exp_a;
            op.frac_b = req_frac_b;
            op.exp_b  = req_exp_b;
            board.note_operation(op);
         end
         if (csr_valid && csr_ready)
            board.set_register(csr_idx_type'(csr_index), csr_wdata);
      end
   end

   // counts cycles without any beat on any channel
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL float_add_subtract");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a falling edge; start stays high afterwards for back-to-back beats
   task automatic push_item(logic sub, logic [FRAC_W-1:0] fa, logic [EXP_W-1:0] ea,
                            logic [FRAC_W-1:0] fb, logic [EXP_W-1:0] eb, int idle_pct);
      int   gap;
      logic taken;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type   = sub;
      req_frac_a = fa;
      req_exp_a  = ea;
      req_frac_b = fb;
      req_exp_b  = eb;
      start      = 1'b1;
      do begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic push_random_item(int idle_pct);
      logic [FRAC_W-1:0] fa, fb;
      logic [EXP_W-1:0]  ea, eb;
      int                pick, delta, t;
      fa = FRAC_W'($urandom);
      pick = $urandom_range(15);
      if (pick == 0) fa = '0;
      else if (pick == 1) fa = '1;
      ea = EXP_W'($urandom);
      if ($urandom_range(15) == 0) begin
         pick = $urandom_range(3);
         ea = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd254 : 8'd255;
      end
      // near-equal fractions stress the normalize pass on subtraction
      pick = $urandom_range(9);
      if (pick < 3) fb = fa ^ (FRAC_W'($urandom) >> $urandom_range(FRAC_W - 1));
      else if (pick == 3) fb = '0;
      else if (pick == 4) fb = '1;
      else fb = FRAC_W'($urandom);
      pick = $urandom_range(9);
      if (pick < 6) delta = int'($urandom_range(4)) - 2;
      else if (pick < 8) delta = int'($urandom_range(140)) - 70;
      else delta = int'($urandom_range(255)) - int'(ea);
      t = int'(ea) + delta;
      if (t < 0 || t > 255) t = int'(ea);
      eb = EXP_W'(t);
      push_item(1'($urandom_range(1)), fa, ea, fb, eb, idle_pct);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      do @(negedge clock); while (board.pending() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(csr_idx_type idx, logic [CSR_W-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      int frac_setting [8] = '{23, 0, 1, 31, 22, -1, 24, -1};
      int exp_setting  [8] = '{8, 0, 1, 31, 7, -1, 16, -1};
      int idle_setting [4] = '{0, 81, 0, 8};
      int fv, ev;
      board = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      push_item(1'b0, 23'h000000, 8'd127, 23'h000000, 8'd127, 0);
      push_item(1'b1, 23'h123456, 8'd90,  23'h123456, 8'd90,  0);
      push_item(1'b1, 23'h000000, 8'd127, 23'h000000, 8'd128, 0);
      push_item(1'b0, 23'h7fffff, 8'd254, 23'h7fffff, 8'd254, 0);
      push_item(1'b1, 23'h000000, 8'd255, 23'h000000, 8'd0,   0);
      push_item(1'b1, 23'h000000, 8'd0,   23'h7fffff, 8'd255, 0);
      push_item(1'b0, 23'h000000, 8'd0,   23'h000000, 8'd0,   0);
      push_item(1'b1, 23'h000001, 8'd1,   23'h000000, 8'd1,   0);
      push_item(1'b1, 23'h7fffff, 8'd0,   23'h000000, 8'd0,   0);
      // alignment just inside and right at the edge of the guard window
      push_item(1'b0, 23'h000000, 8'd200, 23'h7fffff, 8'd137, 0);
      push_item(1'b0, 23'h000000, 8'd200, 23'h7fffff, 8'd136, 0);
      push_item(1'b1, 23'h000000, 8'd136, 23'h7fffff, 8'd200, 0);
      push_item(1'b1, 23'h000000, 8'd128, 23'h7fffff, 8'd127, 0);
      push_item(1'b0, 23'h7fffff, 8'd100, 23'h7fffff, 8'd100, 0);
      push_item(1'b1, 23'h7fffff, 8'd254, 23'h000000, 8'd254, 0);
      push_item(1'b0, 23'h000000, 8'd254, 23'h000000, 8'd253, 0);
      push_item(1'b1, 23'h555555, 8'd60,  23'h2aaaaa, 8'd61,  0);
      push_item(1'b0, 23'h2aaaaa, 8'd255, 23'h555555, 8'd0,   0);
      push_item(1'b1, 23'h000000, 8'd1,   23'h7fffff, 8'd0,   0);
      push_item(1'b0, 23'h000000, 8'd253, 23'h000000, 8'd253, 0);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         fv = (frac_setting[ph] < 0) ? int'($urandom_range(31)) : frac_setting[ph];
         ev = (exp_setting[ph] < 0) ? int'($urandom_range(31)) : exp_setting[ph];
         write_register(CSR_FRAC_BITS, CSR_W'(fv));
         write_register(CSR_EXP_BITS, CSR_W'(ev));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) push_random_item(idle_setting[ph % 4]);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS float_add_subtract");
      end else begin
         $display("FAIL float_add_subtract");
      end
      $finish;
   end

endmodule
